@@ design/lcf_pkg.sv @@
package lcf_pkg;

	// filter geometry
	localparam int MAX_TAPS = 2048;
	localparam int ADDR_W = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int DATA_W = 16;

	// operation codes of an input beat
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PUSH  = 2'd2
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clr;
		logic valid;
	} mac_ctrl_t;

endpackage

@@ design/lcf_in_if.sv @@
interface lcf_in_if;
	import lcf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic signed [DATA_W-1:0] sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink (input valid, input operation, input sample, output ready);

endinterface

@@ design/lcf_out_if.sv @@
interface lcf_out_if;
	import lcf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sum_out;

	modport source (output valid, output sum_out, input ready);
	modport sink (input valid, input sum_out, output ready);

endinterface

@@ design/lcf_mac.sv @@
module lcf_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lcf_pkg::mac_ctrl_t               ctrl,
	input  logic signed [lcf_pkg::DATA_W-1:0] coeff,
	input  logic signed [lcf_pkg::DATA_W-1:0] hist,
	output logic signed [lcf_pkg::DATA_W-1:0] acc,
	output logic                             busy
);
	import lcf_pkg::*;

	logic signed [2*DATA_W-1:0] prod_full;
	logic signed [DATA_W-1:0]   prod_s2;
	logic                       v_s2;
	logic signed [DATA_W-1:0]   acc_q;

	// full product; only the low word reaches the wrapped sum
	assign prod_full = coeff * hist;

	// product register
	always_ff @(posedge clk) begin
		prod_s2 <= prod_full[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl.valid;
		end
	end

	// accumulator, wraps modulo 2^16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign acc = acc_q;
	assign busy = v_s2;

endmodule

@@ design/linear_convolution_fir.sv @@
// Streaming direct-form FIR filter computing the linear convolution of a
// 16-bit signal with a loaded impulse response of up to 2048 taps. A clear beat
// (operation 0) empties the tap list and makes all earlier samples count as
// zero; a load beat (operation 1) appends one coefficient, and is dropped once
// 2048 taps are held; a push beat (operation 2) stores a sample and returns
// one result, the sum of h[k]*x[n-k] over the loaded taps, wrapped to 16 bits.
// Operation 3 is ignored. A push walks the loaded taps: one shared 16x16
// multiply-accumulate unit handles one tap per cycle, fed by one read port
// each of the coefficient and history memories, through the read, product
// and output register stages. No input beat is taken while a push is in
// progress. Samples older than the last clear are masked by a fill count, so
// there is no clearing pass after reset or clear. Pushing tap_count-1 zeros
// after the signal yields the convolution tail.
module linear_convolution_fir (
	input  logic       clk,
	input  logic       arst_n,
	lcf_in_if.sink     item,
	lcf_out_if.source  result
);
	import lcf_pkg::*;

	state_t                   state_q;
	state_t                   state_d;
	logic [CNT_W-1:0]         tap_count_q;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         k_q;
	logic [ADDR_W-1:0]        hptr_q;
	logic [ADDR_W-1:0]        base_q;

	logic signed [DATA_W-1:0] coeff_mem [MAX_TAPS];
	logic signed [DATA_W-1:0] hist_mem [MAX_TAPS];
	logic signed [DATA_W-1:0] coeff_s1;
	logic signed [DATA_W-1:0] hist_s1;
	logic                     rd_v_s1;
	logic                     live_s1;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] sum_q;

	logic                     accept;
	logic                     do_clear;
	logic                     do_load;
	logic                     do_push;
	logic                     issue;
	logic                     last_tap;
	logic                     drained;
	logic                     finish;
	mac_ctrl_t                mac_ctrl;
	logic signed [DATA_W-1:0] mac_hist;
	logic signed [DATA_W-1:0] mac_acc;
	logic                     mac_busy;

	// operation decode of an accepted beat
	assign accept = item.valid && item.ready;

	always_comb begin
		do_clear = 1'b0;
		do_load = 1'b0;
		do_push = 1'b0;
		unique case (op_t'(item.operation))
			OP_CLEAR: do_clear = accept;
			OP_LOAD:  do_load = accept && (tap_count_q != CNT_W'(MAX_TAPS));
			OP_PUSH:  do_push = accept;
			default: begin
			end
		endcase
	end

	assign last_tap = (k_q == tap_count_q);
	assign drained = !rd_v_s1 && !mac_busy;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (do_push) state_d = ST_RUN;
			ST_RUN:   if (last_tap) state_d = ST_DRAIN;
			ST_DRAIN: if (finish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready = 1'b0;
		issue = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ST_IDLE:  item.ready = 1'b1;
			ST_RUN:   issue = !last_tap;
			ST_DRAIN: finish = drained && (!out_valid_q || result.ready);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tap count, fill count and history pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= '0;
			fill_q <= '0;
			hptr_q <= '0;
			base_q <= '0;
		end else if (do_clear) begin
			tap_count_q <= '0;
			fill_q <= '0;
			hptr_q <= '0;
		end else if (do_load) begin
			tap_count_q <= tap_count_q + CNT_W'(1);
		end else if (do_push) begin
			base_q <= hptr_q;
			hptr_q <= hptr_q + ADDR_W'(1);
			if (fill_q != CNT_W'(MAX_TAPS)) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (do_push) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + CNT_W'(1);
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (do_load) begin
			coeff_mem[tap_count_q[ADDR_W-1:0]] <= item.sample;
		end
		coeff_s1 <= coeff_mem[k_q[ADDR_W-1:0]];
	end

	// history memory, read walks back from the newest sample
	always_ff @(posedge clk) begin
		if (do_push) begin
			hist_mem[hptr_q] <= item.sample;
		end
		hist_s1 <= hist_mem[base_q - k_q[ADDR_W-1:0]];
	end

	// read stage flags; taps reaching past the last clear see zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			live_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			live_s1 <= (k_q < fill_q);
		end
	end

	assign mac_hist = live_s1 ? hist_s1 : '0;
	assign mac_ctrl.clr = do_push;
	assign mac_ctrl.valid = rd_v_s1;

	lcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coeff  (coeff_s1),
		.hist   (mac_hist),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sum_q <= mac_acc;
		end
	end

	assign result.valid = out_valid_q;
	assign result.sum_out = sum_q;

endmodule
